@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nas_pkg.sv @@
package nas_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int FRAC_BITS     = 16;
  localparam int CFG_W         = 10;
  localparam int LIFE_W        = 11;
  localparam logic [CFG_W-1:0] LIFE_RESET = 10'd510;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [31:0]       vel_x;
    logic signed [31:0]       vel_y;
    logic signed [LIFE_W-1:0] life;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [8:0]         alpha;
    logic               removed;
    logic               last;
    logic               add_dropped;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD,
    ST_SELF_RD,
    ST_SELF_LAT,
    ST_PAIR_RD,
    ST_PAIR_DIFF,
    ST_PAIR_SQ,
    ST_PAIR_D2,
    ST_DIVX_GO,
    ST_DIVX,
    ST_DIVY_GO,
    ST_DIVY,
    ST_VEL,
    ST_POS,
    ST_EMIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_NEXT
  } state_e;

endpackage

@@ rtl/nas_mem.sv @@
module nas_mem #(
  parameter int DEPTH = nas_pkg::MAX_PARTICLES
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  nas_pkg::entry_t          wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output nas_pkg::entry_t          rdata_o
);

  nas_pkg::entry_t mem [DEPTH];
  nas_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nas_div.sv @@
module nas_div #(
  parameter int FRAC_BITS = nas_pkg::FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [33+FRAC_BITS-1:0] dividend_i,
  input  logic [15+FRAC_BITS-1:0] divisor_i,
  output logic                    done_o,
  output logic [33+FRAC_BITS-1:0] quot_o
);

  localparam int DW  = 33 + FRAC_BITS;
  localparam int VW  = 15 + FRAC_BITS;
  localparam int CNW = $clog2(DW);

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [DW-1:0]  dvd_q;
  logic [VW-1:0]  rem_q, rem_d, dsr_q;
  logic [VW:0]    trial;
  logic           qbit;

  // One quotient bit per cycle, restoring.
  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = VW'(trial - {1'b0, dsr_q});
      qbit  = 1'b1;
    end else begin
      rem_d = trial[VW-1:0];
      qbit  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNW'(1);
        if (cnt_q == CNW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ rtl/nas_core.sv @@
module nas_core #(
  parameter int MAX_PARTICLES = nas_pkg::MAX_PARTICLES,
  parameter int FRAC_BITS     = nas_pkg::FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [11:0]               spawn_x_i,
  input  logic [11:0]               spawn_y_i,
  input  logic [nas_pkg::CFG_W-1:0] initial_life_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output nas_pkg::res_t             res_o
);

  localparam int IW  = $clog2(MAX_PARTICLES);
  localparam int CW  = $clog2(MAX_PARTICLES + 1);
  localparam int DW  = 33 + FRAC_BITS;
  localparam int VW  = 15 + FRAC_BITS;
  localparam int AW  = DW + 7;
  localparam int MW  = FRAC_BITS + 6;
  localparam int SW  = 2 * MW;
  localparam int SPW = 12 + FRAC_BITS;
  localparam logic [MW-1:0] LIM   = MW'(32) << FRAC_BITS;
  localparam logic [SW:0]   D2_LO = (SW+1)'(1) << (2 * FRAC_BITS);
  localparam logic [SW:0]   D2_HI = (SW+1)'(1000) << (2 * FRAC_BITS);
  localparam logic signed [32:0] FRAC_MASK = (33'sd1 <<< FRAC_BITS) - 33'sd1;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  nas_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, j_q;
  logic [IW-1:0]   i_q;
  logic [11:0]     spx_q, spy_q;
  nas_pkg::entry_t self_q;
  logic            negx_q, negy_q, gone_q;
  logic [32:0]     magx_q, magy_q;
  logic [MW-1:0]   cx_q, cy_q;
  logic [SW-1:0]   sqx_q, sqy_q;
  logic [VW-1:0]   dsr_q;
  logic signed [AW-1:0] accx_q, accy_q;
  nas_pkg::res_t   res_q;

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  nas_pkg::entry_t mem_wdata, mem_rdata;
  logic            div_start, div_done;
  logic [DW-1:0]   div_dvd, div_quot;

  logic            full, j_end, j_self;
  logic signed [32:0] dx, dy;
  logic [32:0]     magx_c, magy_c;
  logic [MW-1:0]   cx_c, cy_c;
  logic [SW:0]     d2_sum, d2_c, d2_s;
  logic [VW-1:0]   dsr_c;
  logic signed [AW-1:0] q_s, force_c;
  logic signed [AW:0]   vsx, vsy;
  logic signed [31:0]   posx_new, posy_new;
  logic signed [nas_pkg::LIFE_W-1:0] life_new;
  logic            gone_c;
  logic [SPW-1:0]  spx_w, spy_w;
  nas_pkg::entry_t spawn_e;

  nas_mem #(.DEPTH(MAX_PARTICLES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  nas_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (dsr_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  function automatic logic [31:0] sat_acc(input logic signed [AW:0] v);
    if (v[AW:31] == '0 || v[AW:31] == '1) begin
      return v[31:0];
    end
    return v[AW] ? INT_MIN : INT_MAX;
  endfunction

  function automatic logic [31:0] sat_add(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] == s[31]) begin
      return s[31:0];
    end
    return s[32] ? INT_MIN : INT_MAX;
  endfunction

  // Truncate toward zero to whole pixels, then saturate to 16 bits.
  function automatic logic [15:0] to_pixel(input logic signed [31:0] p);
    logic signed [32:0] pa, q;
    pa = {p[31], p} + (p[31] ? FRAC_MASK : 33'sd0);
    q  = pa >>> FRAC_BITS;
    if (q[32:15] == '0 || q[32:15] == '1) begin
      return q[15:0];
    end
    return q[32] ? 16'h8000 : 16'h7fff;
  endfunction

  function automatic logic [31:0] spawn_pos(input logic [SPW-1:0] v);
    if ((v >> 31) != '0) begin
      return INT_MAX;
    end
    return 32'(v);
  endfunction

  assign full   = (count_q == CW'(MAX_PARTICLES));
  assign j_end  = (j_q == count_q);
  assign j_self = (j_q == {{(CW-IW){1'b0}}, i_q});

  always_comb begin
    dx      = $signed({mem_rdata.pos_x[31], mem_rdata.pos_x})
            - $signed({self_q.pos_x[31], self_q.pos_x});
    dy      = $signed({mem_rdata.pos_y[31], mem_rdata.pos_y})
            - $signed({self_q.pos_y[31], self_q.pos_y});
    magx_c  = dx[32] ? (~dx + 33'd1) : dx;
    magy_c  = dy[32] ? (~dy + 33'd1) : dy;
    cx_c    = (magx_c > 33'(LIM)) ? LIM : magx_c[MW-1:0];
    cy_c    = (magy_c > 33'(LIM)) ? LIM : magy_c[MW-1:0];
    d2_sum  = (SW+1)'(sqx_q) + (SW+1)'(sqy_q);
    if (d2_sum < D2_LO) begin
      d2_c = D2_LO;
    end else if (d2_sum > D2_HI) begin
      d2_c = D2_HI;
    end else begin
      d2_c = d2_sum;
    end
    d2_s    = d2_c >> FRAC_BITS;
    // times 20 as 16x + 4x
    dsr_c   = VW'(d2_s << 4) + VW'(d2_s << 2);
    q_s     = $signed(AW'(div_quot));
    force_c = ((state_q == nas_pkg::ST_DIVX) ? negx_q : negy_q) ? -q_s : q_s;
    vsx     = $signed({{(AW+1-32){self_q.vel_x[31]}}, self_q.vel_x})
            + $signed({accx_q[AW-1], accx_q});
    vsy     = $signed({{(AW+1-32){self_q.vel_y[31]}}, self_q.vel_y})
            + $signed({accy_q[AW-1], accy_q});
    posx_new = sat_add(self_q.pos_x, self_q.vel_x);
    posy_new = sat_add(self_q.pos_y, self_q.vel_y);
    life_new = self_q.life - nas_pkg::LIFE_W'(1);
    gone_c   = life_new[nas_pkg::LIFE_W-1] || (life_new == '0);
    spx_w    = {spx_q, {FRAC_BITS{1'b0}}};
    spy_w    = {spy_q, {FRAC_BITS{1'b0}}};
    spawn_e.pos_x = spawn_pos(spx_w);
    spawn_e.pos_y = spawn_pos(spy_w);
    spawn_e.vel_x = '0;
    spawn_e.vel_y = '0;
    spawn_e.life  = {1'b0, initial_life_i};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nas_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == nas_pkg::CMD_ADD) begin
            state_d = nas_pkg::ST_ADD;
          end else if (count_q != '0) begin
            state_d = nas_pkg::ST_SELF_RD;
          end
        end
      end
      nas_pkg::ST_ADD:       state_d = full ? nas_pkg::ST_EMIT : nas_pkg::ST_IDLE;
      nas_pkg::ST_SELF_RD:   state_d = nas_pkg::ST_SELF_LAT;
      nas_pkg::ST_SELF_LAT:  state_d = nas_pkg::ST_PAIR_RD;
      nas_pkg::ST_PAIR_RD: begin
        if (j_end) begin
          state_d = nas_pkg::ST_VEL;
        end else if (!j_self) begin
          state_d = nas_pkg::ST_PAIR_DIFF;
        end
      end
      nas_pkg::ST_PAIR_DIFF: state_d = nas_pkg::ST_PAIR_SQ;
      nas_pkg::ST_PAIR_SQ:   state_d = nas_pkg::ST_PAIR_D2;
      nas_pkg::ST_PAIR_D2:   state_d = nas_pkg::ST_DIVX_GO;
      nas_pkg::ST_DIVX_GO:   state_d = nas_pkg::ST_DIVX;
      nas_pkg::ST_DIVX:      state_d = div_done ? nas_pkg::ST_DIVY_GO : nas_pkg::ST_DIVX;
      nas_pkg::ST_DIVY_GO:   state_d = nas_pkg::ST_DIVY;
      nas_pkg::ST_DIVY:      state_d = div_done ? nas_pkg::ST_PAIR_RD : nas_pkg::ST_DIVY;
      nas_pkg::ST_VEL:       state_d = nas_pkg::ST_POS;
      nas_pkg::ST_POS:       state_d = nas_pkg::ST_EMIT;
      nas_pkg::ST_EMIT: begin
        if (res_ready_i) begin
          if (res_q.add_dropped) begin
            state_d = nas_pkg::ST_IDLE;
          end else if (gone_q) begin
            state_d = nas_pkg::ST_SHIFT_RD;
          end else begin
            state_d = nas_pkg::ST_NEXT;
          end
        end
      end
      nas_pkg::ST_SHIFT_RD:  state_d = j_end ? nas_pkg::ST_NEXT : nas_pkg::ST_SHIFT_WR;
      nas_pkg::ST_SHIFT_WR:  state_d = nas_pkg::ST_SHIFT_RD;
      nas_pkg::ST_NEXT:      state_d = (i_q == '0) ? nas_pkg::ST_IDLE : nas_pkg::ST_SELF_RD;
      default:               state_d = nas_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory/divider control
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = j_q[IW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = spawn_e;
    div_start   = 1'b0;
    div_dvd     = {magx_q, {FRAC_BITS{1'b0}}};
    unique case (state_q)
      nas_pkg::ST_IDLE: in_ready_o = 1'b1;
      nas_pkg::ST_ADD: begin
        mem_we    = !full;
        mem_waddr = count_q[IW-1:0];
      end
      nas_pkg::ST_SELF_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q;
      end
      nas_pkg::ST_PAIR_RD: mem_re = !j_end && !j_self;
      nas_pkg::ST_DIVX_GO: div_start = 1'b1;
      nas_pkg::ST_DIVY_GO: begin
        div_start = 1'b1;
        div_dvd   = {magy_q, {FRAC_BITS{1'b0}}};
      end
      nas_pkg::ST_POS: begin
        mem_we          = 1'b1;
        mem_wdata       = self_q;
        mem_wdata.pos_x = posx_new;
        mem_wdata.pos_y = posy_new;
        mem_wdata.life  = life_new;
      end
      nas_pkg::ST_EMIT:     res_valid_o = 1'b1;
      nas_pkg::ST_SHIFT_RD: mem_re = !j_end;
      nas_pkg::ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(j_q - CW'(1));
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nas_pkg::ST_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        nas_pkg::ST_IDLE: begin
          if (in_valid_i && cmd_i == nas_pkg::CMD_TICK) begin
            i_q <= IW'(count_q - CW'(1));
          end
        end
        nas_pkg::ST_ADD: begin
          if (!full) begin
            count_q <= count_q + CW'(1);
          end
        end
        nas_pkg::ST_SELF_LAT: j_q <= '0;
        nas_pkg::ST_PAIR_RD: begin
          if (!j_end && j_self) begin
            j_q <= j_q + CW'(1);
          end
        end
        nas_pkg::ST_DIVY: begin
          if (div_done) begin
            j_q <= j_q + CW'(1);
          end
        end
        nas_pkg::ST_EMIT: begin
          // Slide the entries above the removed one down by one.
          j_q <= {{(CW-IW){1'b0}}, i_q} + CW'(1);
        end
        nas_pkg::ST_SHIFT_RD: begin
          if (j_end) begin
            count_q <= count_q - CW'(1);
          end
        end
        nas_pkg::ST_SHIFT_WR: j_q <= j_q + CW'(1);
        nas_pkg::ST_NEXT: begin
          if (i_q != '0) begin
            i_q <= i_q - IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nas_pkg::ST_IDLE: begin
        spx_q <= spawn_x_i;
        spy_q <= spawn_y_i;
      end
      nas_pkg::ST_ADD: begin
        res_q <= '{pixel_x: 16'sd0, pixel_y: 16'sd0, alpha: 9'd0, removed: 1'b0,
                   last: 1'b0, add_dropped: 1'b1};
      end
      nas_pkg::ST_SELF_LAT: begin
        self_q <= mem_rdata;
        accx_q <= '0;
        accy_q <= '0;
      end
      nas_pkg::ST_PAIR_DIFF: begin
        negx_q <= dx[32];
        negy_q <= dy[32];
        magx_q <= magx_c;
        magy_q <= magy_c;
        cx_q   <= cx_c;
        cy_q   <= cy_c;
      end
      nas_pkg::ST_PAIR_SQ: begin
        sqx_q <= cx_q * cx_q;
        sqy_q <= cy_q * cy_q;
      end
      nas_pkg::ST_PAIR_D2: dsr_q <= dsr_c;
      nas_pkg::ST_DIVX: begin
        if (div_done) begin
          accx_q <= accx_q + force_c;
        end
      end
      nas_pkg::ST_DIVY: begin
        if (div_done) begin
          accy_q <= accy_q + force_c;
        end
      end
      nas_pkg::ST_VEL: begin
        self_q.vel_x <= sat_acc(vsx);
        self_q.vel_y <= sat_acc(vsy);
      end
      nas_pkg::ST_POS: begin
        gone_q            <= gone_c;
        res_q.pixel_x     <= to_pixel(posx_new);
        res_q.pixel_y     <= to_pixel(posy_new);
        res_q.alpha       <= gone_c ? 9'd0 : life_new[9:1];
        res_q.removed     <= gone_c;
        res_q.last        <= (i_q == '0);
        res_q.add_dropped <= 1'b0;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

@@ rtl/nbody_attraction_step_top.sv @@
// Add: accepted in IDLE and written to the table in ST_ADD; a full table yields one flagged result.
// Tick: per particle, N-1 pair steps, each running two serial divides on one shared restoring
// divider, then a velocity and position update and one result; when a particle expires, the
// entries above it are compacted down by one. Positions and velocities are Q16.16.
// One transaction is worked at a time; results leave through a one-entry output register.
// Reset: particle count cleared, initial life set to 510; particle memory undefined.
`include "assert_macros.svh"

module nbody_attraction_step_top #(
  parameter int MAX_PARTICLES = nas_pkg::MAX_PARTICLES,
  parameter int FRAC_BITS     = nas_pkg::FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [11:0]               spawn_x_i,
  input  logic [11:0]               spawn_y_i,
  input  logic                      cfg_we_i,
  input  logic [nas_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [15:0]        pixel_x_o,
  output logic signed [15:0]        pixel_y_o,
  output logic [8:0]                alpha_o,
  output logic                      removed_o,
  output logic                      last_o,
  output logic                      add_dropped_o
);

  logic [nas_pkg::CFG_W-1:0] initial_life_q;
  logic                      out_valid_q;
  nas_pkg::res_t             out_q, res;
  logic                      res_valid, res_ready;

  nas_core #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .spawn_x_i      (spawn_x_i),
    .spawn_y_i      (spawn_y_i),
    .initial_life_i (initial_life_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_life_q <= nas_pkg::LIFE_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        initial_life_q <= cfg_wdata_i;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  // Hold the result until the transaction completes.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = out_q.pixel_x;
  assign pixel_y_o     = out_q.pixel_y;
  assign alpha_o       = out_q.alpha;
  assign removed_o     = out_q.removed;
  assign last_o        = out_q.last;
  assign add_dropped_o = out_q.add_dropped;

  `NAS_ASSERT_IMP(a_drop_clean, out_valid_o && add_dropped_o, !removed_o && !last_o && alpha_o == 9'd0 && pixel_x_o == 16'sd0 && pixel_y_o == 16'sd0, "dropped add carries particle data")
  `NAS_ASSERT_IMP(a_removed_alpha, out_valid_o && removed_o, alpha_o == 9'd0, "removed particle with nonzero alpha")
  `NAS_ASSERT_IMP(a_idle_no_result, in_valid_i && in_ready_o, !res_valid, "input taken while core result pending")
  `NAS_ASSERT_NXT(a_result_loaded, res_valid && res_ready, out_valid_o, "core result not captured")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     SETTLE      = 40;
  localparam int     ITEMS_PER_PHASE = 8;
  localparam int     RAND_MAX_COUNT  = 6;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic       cmd;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [9:0] life;
    bit         typed;
    nas_pkg::res_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = nas_pkg::CMD_ADD;
  logic [11:0] spawn_x_i = '0;
  logic [11:0] spawn_y_i = '0;
  logic cfg_we_i = 1'b0;
  logic [nas_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] pixel_x_o;
  logic signed [15:0] pixel_y_o;
  logic [8:0] alpha_o;
  logic removed_o;
  logic last_o;
  logic add_dropped_o;

  nbody_attraction_step_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .cmd_i(cmd_i), .spawn_x_i(spawn_x_i), .spawn_y_i(spawn_y_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pixel_x_o(pixel_x_o), .pixel_y_o(pixel_y_o), .alpha_o(alpha_o),
    .removed_o(removed_o), .last_o(last_o), .add_dropped_o(add_dropped_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // particle table as the block should hold it
  longint ptx[nas_pkg::MAX_PARTICLES];
  longint pty[nas_pkg::MAX_PARTICLES];
  longint pvx[nas_pkg::MAX_PARTICLES];
  longint pvy[nas_pkg::MAX_PARTICLES];
  int     plife[nas_pkg::MAX_PARTICLES];
  int     part_n = 0;
  int     spawn_life = nas_pkg::LIFE_RESET;

  nas_pkg::res_t pending_pixels[$];
  int     err_count = 0;
  int     send_idle_pct = 0;
  int     rcv_idle_pct = 0;
  longint cycles = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [15:0] to_pix(longint p);
    longint q;
    q = p / 65536;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic longint pull_of(longint d, longint dv);
    longint q;
    q = ((d < 0 ? -d : d) <<< nas_pkg::FRAC_BITS) / dv;
    return d < 0 ? -q : q;
  endfunction

  task automatic apply_add(logic [11:0] sx, logic [11:0] sy);
    nas_pkg::res_t r;
    if (part_n >= nas_pkg::MAX_PARTICLES) begin
      r = '0;
      r.add_dropped = 1'b1;
      pending_pixels.push_back(r);
    end else begin
      ptx[part_n] = longint'(sx) <<< nas_pkg::FRAC_BITS;
      pty[part_n] = longint'(sy) <<< nas_pkg::FRAC_BITS;
      pvx[part_n] = 0;
      pvy[part_n] = 0;
      plife[part_n] = spawn_life;
      part_n++;
    end
  endtask

  task automatic apply_tick();
    longint ax, ay, dx, dy, mx, my, d2, dv;
    longint lim, lo, hi;
    bit gone;
    nas_pkg::res_t r;
    lim = longint'(32) <<< nas_pkg::FRAC_BITS;
    lo = longint'(1) <<< (2 * nas_pkg::FRAC_BITS);
    hi = longint'(1000) <<< (2 * nas_pkg::FRAC_BITS);
    for (int i = part_n - 1; i >= 0; i--) begin
      ax = 0;
      ay = 0;
      for (int j = 0; j < part_n; j++) begin
        if (j != i) begin
          dx = ptx[j] - ptx[i];
          dy = pty[j] - pty[i];
          mx = dx < 0 ? -dx : dx;
          my = dy < 0 ? -dy : dy;
          if (mx > lim) mx = lim;
          if (my > lim) my = lim;
          d2 = mx * mx + my * my;
          if (d2 < lo) d2 = lo;
          if (d2 > hi) d2 = hi;
          dv = 20 * (d2 >>> nas_pkg::FRAC_BITS);
          ax += pull_of(dx, dv);
          ay += pull_of(dy, dv);
        end
      end
      pvx[i] = sat32(pvx[i] + ax);
      pvy[i] = sat32(pvy[i] + ay);
      ptx[i] = sat32(ptx[i] + pvx[i]);
      pty[i] = sat32(pty[i] + pvy[i]);
      plife[i] -= 1;
      gone = plife[i] <= 0;
      r = '0;
      r.pixel_x = to_pix(ptx[i]);
      r.pixel_y = to_pix(pty[i]);
      r.alpha = gone ? 9'd0 : 9'(plife[i] / 2);
      r.removed = gone;
      r.last = (i == 0);
      pending_pixels.push_back(r);
      if (gone) begin
        for (int k = i; k < part_n - 1; k++) begin
          ptx[k] = ptx[k+1];
          pty[k] = pty[k+1];
          pvx[k] = pvx[k+1];
          pvy[k] = pvy[k+1];
          plife[k] = plife[k+1];
        end
        part_n--;
      end
    end
  endtask

  // present one transaction and hold it until accepted
  task automatic send_item(logic cmd, logic [11:0] sx, logic [11:0] sy);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    spawn_x_i <= sx;
    spawn_y_i <= sy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_life(logic [9:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    spawn_life = v;
  endtask

  task automatic random_phase(int n_items);
    logic cmd;
    for (int k = 0; k < n_items; k++) begin
      if (part_n >= RAND_MAX_COUNT) cmd = nas_pkg::CMD_TICK;
      else cmd = ($urandom_range(99) < 40) ? nas_pkg::CMD_TICK : nas_pkg::CMD_ADD;
      if (cmd == nas_pkg::CMD_TICK) begin
        send_item(nas_pkg::CMD_TICK, 12'($urandom), 12'($urandom));
        apply_tick();
      end else begin
        // cluster most spawns so the pull is strong
        if ($urandom_range(3) == 0) begin
          send_item(nas_pkg::CMD_ADD, 12'($urandom), 12'($urandom));
        end else begin
          send_item(nas_pkg::CMD_ADD, 12'($urandom_range(2000, 2040)),
                    12'($urandom_range(2000, 2040)));
        end
        apply_add(spawn_x_i, spawn_y_i);
      end
    end
  endtask

  // output side: stall at random, check each transaction
  always @(posedge clk_i) begin
    nas_pkg::res_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nbody_attraction_step_top: mismatch");
      $finish;
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= rcv_idle_pct);
    if (out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result x=%0d y=%0d", pixel_x_o, pixel_y_o);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x_o !== want.pixel_x || pixel_y_o !== want.pixel_y ||
            alpha_o !== want.alpha || removed_o !== want.removed ||
            last_o !== want.last || add_dropped_o !== want.add_dropped) begin
          err_count++;
          if (err_count <= 10)
            $display("exp x=%0d y=%0d a=%0d rm=%0b l=%0b dr=%0b, got x=%0d y=%0d a=%0d rm=%0b l=%0b dr=%0b",
                     want.pixel_x, want.pixel_y, want.alpha, want.removed, want.last,
                     want.add_dropped, pixel_x_o, pixel_y_o, alpha_o, removed_o, last_o,
                     add_dropped_o);
        end
      end
    end
  end

  stim_row_t rows[$];

  function automatic stim_row_t item_row(logic cmd, logic [11:0] sx, logic [11:0] sy);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.sx = sx;
    r.sy = sy;
    r.life = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    nas_pkg::res_t dropped;
    send_idle_pct = 7;
    rcv_idle_pct = 78;
    rows.push_back(item_row(nas_pkg::CMD_TICK, 12'd0, 12'd0));      // empty table
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd4095, 12'd0));
    r = item_row(nas_pkg::CMD_TICK, 12'd4095, 12'd4095);            // lone particle stays put
    r.typed = 1'b1;
    r.want = '{pixel_x: 16'sd4095, pixel_y: 16'sd0, alpha: 9'd254, removed: 1'b0,
               last: 1'b1, add_dropped: 1'b0};
    rows.push_back(r);
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd0, 12'd4095));
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd2048, 12'd2048));
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd2049, 12'd2048)); // distance of exactly one pixel
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd2048, 12'd2049));
    rows.push_back(item_row(nas_pkg::CMD_TICK, 12'd0, 12'd0));
    rows.push_back(item_row(nas_pkg::CMD_TICK, 12'd0, 12'd0));
    r = item_row(nas_pkg::CMD_ADD, 12'd0, 12'd0);
    r.kind = ROW_CFG;
    r.life = 10'd1023;
    rows.push_back(r);
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd4095, 12'd4095));
    rows.push_back(item_row(nas_pkg::CMD_TICK, 12'd0, 12'd0));
    r.life = 10'd0;
    rows.push_back(r);
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd100, 12'd100));
    rows.push_back(item_row(nas_pkg::CMD_ADD, 12'd101, 12'd100));
    rows.push_back(item_row(nas_pkg::CMD_TICK, 12'd0, 12'd0));      // both expire
    r.life = 10'd1;
    rows.push_back(r);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_life(rows[i].life);
      end else begin
        send_item(rows[i].cmd, rows[i].sx, rows[i].sy);
        if (rows[i].cmd == nas_pkg::CMD_TICK) apply_tick();
        else apply_add(rows[i].sx, rows[i].sy);
        if (rows[i].typed) begin
          void'(pending_pixels.pop_back());
          pending_pixels.push_back(rows[i].want);
        end
      end
    end

    // fill the table with short-lived particles, overflow once, then clear them
    while (part_n < nas_pkg::MAX_PARTICLES) begin
      send_item(nas_pkg::CMD_ADD, 12'($urandom), 12'($urandom));
      apply_add(spawn_x_i, spawn_y_i);
    end
    send_item(nas_pkg::CMD_ADD, 12'd0, 12'd0);
    dropped = '0;
    dropped.add_dropped = 1'b1;
    pending_pixels.push_back(dropped);
    send_item(nas_pkg::CMD_TICK, 12'd0, 12'd0);
    apply_tick();

    write_life(10'd7);
    random_phase(ITEMS_PER_PHASE);

    write_life(10'd1023);
    send_idle_pct = 78;
    rcv_idle_pct = 7;
    random_phase(ITEMS_PER_PHASE);

    write_life(10'($urandom_range(1, 12)));
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    random_phase(ITEMS_PER_PHASE);

    drain();
    if (err_count == 0) begin
      $display("nbody_attraction_step_top: match");
    end else begin
      $display("nbody_attraction_step_top: mismatch");
    end
    $finish;
  end

endmodule
